// ===== sv/mcba_pkg.sv =====
// ----------------------------------------------------------------------------
// mcba_pkg: shared definitions for the bipartite assignment solver
// Field widths, default sizes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package mcba_pkg;

  // Default sizes of the vertex sides and of the edge store.
  localparam int MAX_SIDE_DEF  = 256;
  localparam int MAX_EDGES_DEF = 4096;

  // Fixed field widths.
  localparam int VERT_W   = 8;
  localparam int COST_W   = 16;
  localparam int SIDE_W   = 9;
  localparam int TOTAL_W  = 24;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = 25;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ===== sv/mcba_edge_if.sv =====
// ----------------------------------------------------------------------------
// mcba_edge_if: edge channel
// Carries one weighted edge per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface mcba_edge_if;
  logic                        valid;
  logic                        ready;
  logic [mcba_pkg::VERT_W-1:0] left_vertex;
  logic [mcba_pkg::VERT_W-1:0] right_vertex;
  logic [mcba_pkg::COST_W-1:0] edge_cost;
  logic                        last_edge;

  modport source (output valid, left_vertex, right_vertex, edge_cost, last_edge,
                  input ready);
  modport sink   (input valid, left_vertex, right_vertex, edge_cost, last_edge,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/mcba_result_if.sv =====
// ----------------------------------------------------------------------------
// mcba_result_if: result channel
// Carries the total cost and status of one solve per word.
// ----------------------------------------------------------------------------
`default_nettype none
interface mcba_result_if;
  logic                          valid;
  logic                          ready;
  logic [mcba_pkg::TOTAL_W-1:0]  total_cost;
  logic [mcba_pkg::STATUS_W-1:0] status;

  modport source (output valid, total_cost, status, input ready);
  modport sink   (input valid, total_cost, status, output ready);
endinterface
`default_nettype wire

// ===== sv/min_cost_bipartite_assignment.sv =====
// ----------------------------------------------------------------------------
// min_cost_bipartite_assignment: minimum-cost perfect bipartite assignment
// Stores edges, then solves by successive shortest augmenting paths with
// Bellman-Ford passes over the edge store.
// ----------------------------------------------------------------------------
//
//   channel   dir   word                                          handshake
//   edges     in    left_vertex, right_vertex, edge_cost, last    valid/ready
//   results   out   total_cost, status                            valid/ready
//   cfg       in    side_count (9 bits)                           cfg_we
//
// Edges load at one word per cycle while the block is in its load state.
// After the last edge the solver runs: a clear sweep of the edge flags and
// vertex words, then a vertex setup for each augmentation but the first,
// Bellman-Ford passes over the edge store until no distance changes, a sink
// search over the right vertices and a path walk back through each matched
// left vertex on the path; a final sum over the matched edges.
// The edge store's single read port paces every pass.
// Edges are taken again while a result waits; the next solve only reports
// once the result register is empty. Reset is synchronous and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none
module min_cost_bipartite_assignment #(
  parameter int MAX_SIDE  = mcba_pkg::MAX_SIDE_DEF,
  parameter int MAX_EDGES = mcba_pkg::MAX_EDGES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [mcba_pkg::SIDE_W-1:0] cfg_data,
  mcba_edge_if.sink                        edges,
  mcba_result_if.source                    results
);

  localparam int VW  = $clog2(MAX_SIDE);
  localparam int NW  = $clog2(MAX_SIDE + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int KW  = (CW > NW) ? CW : NW;
  localparam int SW  = (NW > mcba_pkg::SIDE_W) ? NW : mcba_pkg::SIDE_W;
  localparam int DW  = $clog2(2 * MAX_SIDE + 2) + mcba_pkg::COST_W + 1;
  localparam int XW  = DW + 2;
  localparam int VTW = mcba_pkg::VERT_W;
  localparam int CSW = mcba_pkg::COST_W;
  localparam int RW  = 2 * VTW + CSW;

  typedef enum logic [4:0] {
    S_LOAD, S_CLR, S_VI_RD, S_VI_WR, S_E_RD, S_E_DAT, S_E_RLX,
    S_SK_RD, S_SK_EV, S_AU0, S_AU1, S_AU2, S_AU3, S_AU4,
    S_SM_RD, S_SM_EV, S_EMIT
  } state_t;

  state_t                      state;
  logic [mcba_pkg::SIDE_W-1:0] side_count;
  logic [CW-1:0]               arc_count;
  logic                        ovf;
  logic [KW-1:0]               k;
  logic [EW-1:0]               e;
  logic                        changed;
  logic                        found;
  logic [VW-1:0]               best_r;
  logic signed [DW-1:0]        best_d;
  logic [VTW-1:0]              cur_l;
  logic [VTW-1:0]              cur_r;
  logic [CSW-1:0]              cur_c;
  logic                        cur_mt;
  logic [NW-1:0]               pairs;
  logic [mcba_pkg::SUM_W-1:0]  cost_sum;
  mcba_pkg::status_t           status_reg;

  // RAM ports.
  logic          edge_we;
  logic [EW-1:0] edge_waddr, edge_raddr;
  logic [RW-1:0] edge_wdata, edge_rd;
  logic          em_we, em_wdata, em_rd;
  logic [EW-1:0] em_waddr;
  logic          lw_we, rw_we;
  logic [VW-1:0] lw_waddr, lw_raddr, rw_waddr, rw_raddr;
  logic [XW-1:0] lw_wdata, rw_wdata, lw_rd, rw_rd;
  logic          pl_we, pr_we;
  logic [VW-1:0] pl_waddr, pr_waddr, pl_raddr, pr_raddr;
  logic [EW-1:0] pl_rd, pr_rd;

  // Effective side count, clamped to 1..MAX_SIDE.
  logic [SW-1:0] side_ext;
  logic [NW-1:0] n_eff;
  always_comb begin
    side_ext = SW'(side_count);
    if (side_ext == '0) begin
      n_eff = NW'(1);
    end else if (side_ext > SW'(MAX_SIDE)) begin
      n_eff = NW'(MAX_SIDE);
    end else begin
      n_eff = NW'(side_ext);
    end
  end

  // Fields of the edge word read from the store.
  logic [VTW-1:0] rd_l, rd_r;
  logic [CSW-1:0] rd_c;
  logic           rd_valid;
  assign rd_l = edge_rd[RW-1 -: VTW];
  assign rd_r = edge_rd[CSW +: VTW];
  assign rd_c = edge_rd[CSW-1:0];
  assign rd_valid = (SW'(rd_l) < SW'(n_eff)) && (SW'(rd_r) < SW'(n_eff));

  // Vertex words: matched flag, reached flag, distance.
  logic                 lm, lreach, rm, rreach;
  logic signed [DW-1:0] ld, rdist, cand_f, cand_r, cost_s;
  logic                 fwd_ok, rev_ok, sink_hit;
  assign lm     = lw_rd[DW+1];
  assign lreach = lw_rd[DW];
  assign ld     = $signed(lw_rd[DW-1:0]);
  assign rm     = rw_rd[DW+1];
  assign rreach = rw_rd[DW];
  assign rdist  = $signed(rw_rd[DW-1:0]);
  assign cost_s = $signed({{(DW-CSW){1'b0}}, cur_c});
  assign cand_f = ld + cost_s;
  assign cand_r = rdist - cost_s;

  // Relaxation along a free edge forward or a matched edge backward.
  assign fwd_ok   = !cur_mt && lreach && (!rreach || (cand_f < rdist));
  assign rev_ok   = cur_mt && rreach && (!lreach || (cand_r < ld));
  assign sink_hit = !rm && rreach && (!found || (rdist < best_d));

  logic edge_acc, store_full, last_pass_edge, k_last_n, k_last_clr;
  logic [KW-1:0] k_clr_end;
  assign edges.ready    = (state == S_LOAD);
  assign edge_acc       = edges.valid && edges.ready;
  assign store_full     = (arc_count >= CW'(MAX_EDGES));
  assign last_pass_edge = (CW'(e) == arc_count - CW'(1));
  assign k_last_n       = (k == KW'(n_eff) - KW'(1));
  assign k_clr_end      = (KW'(arc_count) > KW'(n_eff)) ? KW'(arc_count) : KW'(n_eff);
  assign k_last_clr     = (k == k_clr_end - KW'(1));

  // RAM address and write control.
  always_comb begin
    edge_we    = edge_acc && !store_full;
    edge_waddr = EW'(arc_count);
    edge_wdata = {edges.left_vertex, edges.right_vertex, edges.edge_cost};
    edge_raddr = e;
    em_we      = 1'b0;
    em_waddr   = EW'(k);
    em_wdata   = 1'b0;
    lw_we      = 1'b0;
    lw_waddr   = VW'(k);
    lw_wdata   = '0;
    lw_raddr   = VW'(k);
    rw_we      = 1'b0;
    rw_waddr   = VW'(k);
    rw_wdata   = '0;
    rw_raddr   = VW'(k);
    pl_we      = 1'b0;
    pl_waddr   = VW'(cur_l);
    pl_raddr   = VW'(rd_l);
    pr_we      = 1'b0;
    pr_waddr   = VW'(cur_r);
    pr_raddr   = best_r;
    case (state)
      S_CLR: begin
        em_we    = (k < KW'(arc_count));
        lw_we    = (k < KW'(n_eff));
        lw_wdata = {1'b0, 1'b1, {DW{1'b0}}};
        rw_we    = (k < KW'(n_eff));
      end
      S_VI_WR: begin
        lw_we    = 1'b1;
        lw_wdata = {lm, !lm, {DW{1'b0}}};
        rw_we    = 1'b1;
        rw_wdata = {rm, 1'b0, {DW{1'b0}}};
      end
      S_E_DAT: begin
        lw_raddr = VW'(rd_l);
        rw_raddr = VW'(rd_r);
      end
      S_E_RLX: begin
        lw_waddr = VW'(cur_l);
        lw_we    = rev_ok;
        lw_wdata = {lm, 1'b1, cand_r};
        pl_we    = rev_ok;
        rw_waddr = VW'(cur_r);
        rw_we    = fwd_ok;
        rw_wdata = {rm, 1'b1, cand_f};
        pr_we    = fwd_ok;
      end
      S_AU0: begin
        rw_we    = 1'b1;
        rw_waddr = best_r;
        rw_wdata = {1'b1, 1'b0, {DW{1'b0}}};
      end
      S_AU1: begin
        em_we      = 1'b1;
        em_waddr   = pr_rd;
        em_wdata   = 1'b1;
        edge_raddr = pr_rd;
      end
      S_AU2: begin
        lw_raddr = VW'(rd_l);
      end
      S_AU3: begin
        lw_we      = !lm;
        lw_waddr   = VW'(cur_l);
        lw_wdata   = {1'b1, 1'b0, {DW{1'b0}}};
        em_we      = lm;
        em_waddr   = pl_rd;
        edge_raddr = pl_rd;
      end
      S_AU4: begin
        pr_raddr = VW'(rd_r);
      end
      default: begin
      end
    endcase
  end

  // Sequencer, registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      side_count    <= mcba_pkg::SIDE_W'(1);
      arc_count     <= '0;
      ovf           <= 1'b0;
      cost_sum      <= '0;
      pairs         <= '0;
      results.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        side_count <= cfg_data;
      end
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        // Store edges; the last one starts the solve, or the report after an overflow.
        S_LOAD: begin
          if (edge_acc) begin
            if (store_full) begin
              ovf <= 1'b1;
            end else begin
              arc_count <= arc_count + CW'(1);
            end
            if (edges.last_edge) begin
              k     <= '0;
              pairs <= '0;
              if (ovf || store_full) begin
                status_reg <= mcba_pkg::ST_OVERFLOW;
                state      <= S_EMIT;
              end else begin
                state <= S_CLR;
              end
            end
          end
        end
        // Clear edge flags and vertex words.
        S_CLR: begin
          k <= k + KW'(1);
          if (k_last_clr) begin
            e       <= '0;
            changed <= 1'b0;
            state   <= S_E_RD;
          end
        end
        // Reset distances, keeping matched flags.
        S_VI_RD: begin
          state <= S_VI_WR;
        end
        S_VI_WR: begin
          k <= k + KW'(1);
          if (k_last_n) begin
            e       <= '0;
            changed <= 1'b0;
            state   <= S_E_RD;
          end else begin
            state <= S_VI_RD;
          end
        end
        // Bellman-Ford pass over the edge store.
        S_E_RD: begin
          state <= S_E_DAT;
        end
        S_E_DAT: begin
          cur_l  <= rd_l;
          cur_r  <= rd_r;
          cur_c  <= rd_c;
          cur_mt <= em_rd;
          if (rd_valid) begin
            state <= S_E_RLX;
          end else if (!last_pass_edge) begin
            e     <= e + EW'(1);
            state <= S_E_RD;
          end else if (changed) begin
            e       <= '0;
            changed <= 1'b0;
            state   <= S_E_RD;
          end else begin
            k     <= '0;
            found <= 1'b0;
            state <= S_SK_RD;
          end
        end
        S_E_RLX: begin
          if (!last_pass_edge) begin
            e       <= e + EW'(1);
            changed <= changed || fwd_ok || rev_ok;
            state   <= S_E_RD;
          end else if (changed || fwd_ok || rev_ok) begin
            e       <= '0;
            changed <= 1'b0;
            state   <= S_E_RD;
          end else begin
            k     <= '0;
            found <= 1'b0;
            state <= S_SK_RD;
          end
        end
        // Nearest free right vertex closes the path to the sink.
        S_SK_RD: begin
          state <= S_SK_EV;
        end
        S_SK_EV: begin
          k <= k + KW'(1);
          if (sink_hit) begin
            found  <= 1'b1;
            best_r <= VW'(k);
            best_d <= rdist;
          end
          if (!k_last_n) begin
            state <= S_SK_RD;
          end else if (found || sink_hit) begin
            state <= S_AU0;
          end else begin
            e          <= '0;
            cost_sum   <= '0;
            status_reg <= (pairs == n_eff) ? mcba_pkg::ST_OK : mcba_pkg::ST_NO_MATCH;
            state      <= S_SM_RD;
          end
        end
        // Walk the path back, flipping edge flags.
        S_AU0: begin
          state <= S_AU1;
        end
        S_AU1: begin
          state <= S_AU2;
        end
        S_AU2: begin
          cur_l <= rd_l;
          state <= S_AU3;
        end
        S_AU3: begin
          if (lm) begin
            state <= S_AU4;
          end else begin
            pairs <= pairs + NW'(1);
            k     <= '0;
            if (pairs + NW'(1) == n_eff) begin
              e          <= '0;
              cost_sum   <= '0;
              status_reg <= mcba_pkg::ST_OK;
              state      <= S_SM_RD;
            end else begin
              state <= S_VI_RD;
            end
          end
        end
        S_AU4: begin
          state <= S_AU1;
        end
        // Sum the costs of matched edges.
        S_SM_RD: begin
          state <= S_SM_EV;
        end
        S_SM_EV: begin
          if (rd_valid && em_rd) begin
            cost_sum <= cost_sum + mcba_pkg::SUM_W'(rd_c);
          end
          if (last_pass_edge) begin
            state <= S_EMIT;
          end else begin
            e     <= e + EW'(1);
            state <= S_SM_RD;
          end
        end
        // Hand over the result once the output register is empty.
        S_EMIT: begin
          if (!results.valid) begin
            results.valid      <= 1'b1;
            results.status     <= status_reg;
            results.total_cost <= (status_reg == mcba_pkg::ST_OK) ?
                                  cost_sum[mcba_pkg::TOTAL_W-1:0] : '0;
            arc_count          <= '0;
            ovf                <= 1'b0;
            state              <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Edge store and matched flags.
  mcba_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rd)
  );
  mcba_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_match_ram (
    .clk(clk), .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
    .raddr(e), .rdata(em_rd)
  );

  // Vertex words and predecessor edges, left and right.
  mcba_ram #(.WIDTH(XW), .DEPTH(MAX_SIDE)) u_left_ram (
    .clk(clk), .we(lw_we), .waddr(lw_waddr), .wdata(lw_wdata),
    .raddr(lw_raddr), .rdata(lw_rd)
  );
  mcba_ram #(.WIDTH(XW), .DEPTH(MAX_SIDE)) u_right_ram (
    .clk(clk), .we(rw_we), .waddr(rw_waddr), .wdata(rw_wdata),
    .raddr(rw_raddr), .rdata(rw_rd)
  );
  mcba_ram #(.WIDTH(EW), .DEPTH(MAX_SIDE)) u_pred_left_ram (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(e),
    .raddr(pl_raddr), .rdata(pl_rd)
  );
  mcba_ram #(.WIDTH(EW), .DEPTH(MAX_SIDE)) u_pred_right_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(e),
    .raddr(pr_raddr), .rdata(pr_rd)
  );

endmodule
`default_nettype wire

// ===== sv/mcba_ram.sv =====
// ----------------------------------------------------------------------------
// mcba_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/mcba_checker.sv =====
// ----------------------------------------------------------------------------
// mcba_checker: port-level checks for the assignment solver
// Watches the edge and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module mcba_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_last,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [mcba_pkg::TOTAL_W-1:0]  total_cost,
  input wire logic [mcba_pkg::STATUS_W-1:0] status
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(total_cost) && $stable(status))
    else $error("result payload changed while stalled");

  // The solve takes over right after the last edge.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("edge taken in the cycle after the last edge");

  // Only defined status codes are reported.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == mcba_pkg::ST_OK || status == mcba_pkg::ST_NO_MATCH ||
                   status == mcba_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // A failed solve reports zero cost.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mcba_pkg::ST_OK |-> total_cost == '0)
    else $error("nonzero cost with failure status");

endmodule

bind min_cost_bipartite_assignment mcba_checker u_mcba_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(edges.valid),
  .in_ready(edges.ready),
  .in_last(edges.last_edge),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .total_cost(results.total_cost),
  .status(results.status)
);
`default_nettype wire

// ===== sim/min_cost_bipartite_assignment_test.sv =====
// ----------------------------------------------------------------------------
// min_cost_bipartite_assignment_test: self-checking bench for the solver
// Streams edge graphs into the block and checks each solved total and status
// against a successive-shortest-path solver that runs in the bench. It covers
// directed corner graphs and random graphs under varied stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: collects the edges of the graph in flight, solves it when the
// last edge is accepted and holds the expected result words.
class assignment_scoreboard;
  typedef struct {
    logic [mcba_pkg::TOTAL_W-1:0] total;
    mcba_pkg::status_t            status;
  } result_word_t;

  int           side_reg = 1;
  int           graph_left[$];
  int           graph_right[$];
  int           graph_cost[$];
  bit           spilled = 0;
  result_word_t pending_results[$];
  int           error_count = 0;

  task report(string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  // Min-cost max-flow over the unit-capacity residual graph.
  function void solve_graph(output logic [mcba_pkg::TOTAL_W-1:0] total,
                            output mcba_pkg::status_t status);
    int     n, src, snk, v, a, matched, pairs, k;
    int     tail_q[$], head_q[$], cost_q[$], cap_q[$];
    longint node_dist[];
    int     pred[];
    bit     changed;
    longint sum;
    longint far_off;
    far_off = 64'sh3fff_ffff_ffff_ffff;
    n = (side_reg == 0) ? 1 :
        (side_reg > mcba_pkg::MAX_SIDE_DEF ? mcba_pkg::MAX_SIDE_DEF : side_reg);
    src = 2 * n;
    snk = 2 * n + 1;
    pairs = 0;
    for (k = 0; k < graph_left.size(); k++) begin
      if (graph_left[k] < n && graph_right[k] < n) begin
        tail_q = {tail_q, graph_left[k]}; head_q = {head_q, n + graph_right[k]};
        cost_q = {cost_q, graph_cost[k]}; cap_q = {cap_q, 1};
        tail_q = {tail_q, n + graph_right[k]}; head_q = {head_q, graph_left[k]};
        cost_q = {cost_q, -graph_cost[k]}; cap_q = {cap_q, 0};
        pairs++;
      end
    end
    for (k = 0; k < n; k++) begin
      tail_q = {tail_q, src}; head_q = {head_q, k}; cost_q = {cost_q, 0}; cap_q = {cap_q, 1};
      tail_q = {tail_q, k}; head_q = {head_q, src}; cost_q = {cost_q, 0}; cap_q = {cap_q, 0};
      tail_q = {tail_q, n + k}; head_q = {head_q, snk}; cost_q = {cost_q, 0};
      cap_q = {cap_q, 1};
      tail_q = {tail_q, snk}; head_q = {head_q, n + k}; cost_q = {cost_q, 0};
      cap_q = {cap_q, 0};
    end
    node_dist = new[2 * n + 2];
    pred = new[2 * n + 2];
    matched = 0;
    while (matched < n) begin
      foreach (node_dist[i]) node_dist[i] = far_off;
      node_dist[src] = 0;
      // Bellman-Ford relaxation until nothing changes.
      do begin
        changed = 0;
        for (a = 0; a < tail_q.size(); a++) begin
          if (cap_q[a] != 0 && node_dist[tail_q[a]] != far_off &&
              node_dist[tail_q[a]] + cost_q[a] < node_dist[head_q[a]]) begin
            node_dist[head_q[a]] = node_dist[tail_q[a]] + cost_q[a];
            pred[head_q[a]] = a;
            changed = 1;
          end
        end
      end while (changed);
      if (node_dist[snk] == far_off) break;
      v = snk;
      while (v != src) begin
        a = pred[v];
        cap_q[a] = 0;
        cap_q[a ^ 1] = 1;
        v = tail_q[a];
      end
      matched++;
    end
    sum = 0;
    for (k = 0; k < pairs; k++)
      if (cap_q[2 * k] == 0) sum += cost_q[2 * k];
    if (matched == n) begin
      total = sum[mcba_pkg::TOTAL_W-1:0];
      status = mcba_pkg::ST_OK;
    end else begin
      total = '0;
      status = mcba_pkg::ST_NO_MATCH;
    end
  endfunction

  // Note one accepted edge word; the last edge closes the graph.
  function void note_edge(int l, int r, int c, bit last);
    result_word_t exp_word;
    if (graph_left.size() < mcba_pkg::MAX_EDGES_DEF) begin
      graph_left = {graph_left, l}; graph_right = {graph_right, r};
      graph_cost = {graph_cost, c};
    end else begin
      spilled = 1;
    end
    if (!last) return;
    if (spilled) begin
      exp_word.total = '0;
      exp_word.status = mcba_pkg::ST_OVERFLOW;
    end else begin
      solve_graph(exp_word.total, exp_word.status);
    end
    pending_results = {pending_results, exp_word};
    graph_left.delete(); graph_right.delete(); graph_cost.delete();
    spilled = 0;
  endfunction

  task check_result(logic [mcba_pkg::TOTAL_W-1:0] total,
                    logic [mcba_pkg::STATUS_W-1:0] status);
    result_word_t exp_word;
    if (pending_results.size() == 0) begin
      report($sformatf("result word total=%0d status=%0d with nothing expected",
                       total, status));
      return;
    end
    exp_word = pending_results.pop_front();
    if (status !== exp_word.status)
      report($sformatf("status %0d, expected %0d", status, exp_word.status));
    if (total !== exp_word.total)
      report($sformatf("total_cost %0d, expected %0d", total, exp_word.total));
  endtask
endclass

module min_cost_bipartite_assignment_test;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int EDGE_TARGET = 735;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [mcba_pkg::SIDE_W-1:0] cfg_data;
  int                          send_idle_pct;
  int                          recv_idle_pct;
  int                          cycle_count = 0;

  mcba_edge_if   edge_ch ();
  mcba_result_if res_ch ();

  assignment_scoreboard sb = new();

  min_cost_bipartite_assignment dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .edges    (edge_ch),
    .results  (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("min_cost_bipartite_assignment_test: errors");
      $finish;
    end
  end

  // Result side: random back-pressure at the falling edge.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted result word.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.total_cost, res_ch.status);
  end

  // Present one edge word, with random idle cycles ahead of it.
  task automatic send_edge(int l, int r, int c, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      edge_ch.valid = 1'b0;
    end
    @(negedge clk);
    edge_ch.valid        = 1'b1;
    edge_ch.left_vertex  = l[mcba_pkg::VERT_W-1:0];
    edge_ch.right_vertex = r[mcba_pkg::VERT_W-1:0];
    edge_ch.edge_cost    = c[mcba_pkg::COST_W-1:0];
    edge_ch.last_edge    = last;
    do @(posedge clk); while (!edge_ch.ready);
    sb.note_edge(l, r, c, last);
  endtask

  // Let every expected word come back, then the solver settle.
  task automatic drain_results();
    @(negedge clk);
    edge_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Side count may only change while the block is idle.
  task automatic write_side(int value);
    drain_results();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value[mcba_pkg::SIDE_W-1:0];
    @(negedge clk);
    cfg_we   = 1'b0;
    sb.side_reg = value & 'h1FF;
  endtask

  function automatic int pick_cost();
    return ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(65535);
  endfunction

  // One random graph; a well-formed one always holds a perfect matching.
  task automatic send_random_graph(int n, bit noisy, inout int sent);
    int l_q[$], r_q[$], perm[$];
    int count, k, j, tmp;
    if (noisy) begin
      count = $urandom_range(1, 10);
      for (k = 0; k < count; k++) begin
        l_q = {l_q, ($urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(255))};
        r_q = {r_q, ($urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(255))};
      end
    end else begin
      for (k = 0; k < n; k++) perm = {perm, k};
      for (k = n - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = perm[k]; perm[k] = perm[j]; perm[j] = tmp;
      end
      for (k = 0; k < n; k++) begin
        l_q = {l_q, k}; r_q = {r_q, perm[k]};
      end
      count = $urandom_range(0, 2 * n);
      for (k = 0; k < count; k++) begin
        l_q = {l_q, int'($urandom_range(n - 1))};
        r_q = {r_q, int'($urandom_range(n - 1))};
      end
      // Shuffle so the permutation edges are not in order.
      for (k = l_q.size() - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = l_q[k]; l_q[k] = l_q[j]; l_q[j] = tmp;
        tmp = r_q[k]; r_q[k] = r_q[j]; r_q[j] = tmp;
      end
    end
    for (k = 0; k < l_q.size(); k++)
      send_edge(l_q[k], r_q[k], pick_cost(), k == l_q.size() - 1);
    sent += l_q.size();
  endtask

  initial begin
    int sent, graphs, side;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    edge_ch.valid = 1'b0;
    edge_ch.left_vertex = '0;
    edge_ch.right_vertex = '0;
    edge_ch.edge_cost = '0;
    edge_ch.last_edge = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 77;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed graphs: default side of one, then the side count extremes.
    send_edge(0, 0, 65535, 1);
    write_side(0);
    send_edge(1, 0, 5, 0);
    send_edge(0, 0, 0, 1);
    write_side(2);
    send_edge(0, 0, 1, 0);
    send_edge(0, 1, 65535, 0);
    send_edge(1, 0, 65535, 0);
    send_edge(1, 1, 2, 1);
    send_edge(0, 0, 1, 0);
    send_edge(1, 0, 2, 1);
    write_side(256);
    send_edge(255, 255, 65535, 0);
    send_edge(0, 0, 3, 0);
    send_edge(1, 1, 4, 1);
    write_side(511);
    send_edge(0, 0, 1, 0);
    send_edge(0, 1, 2, 1);

    // A single-edge graph at a side count of one.
    write_side(1);
    send_edge(0, 0, 9, 1);

    // Random graphs through three stall profiles.
    sent = 0;
    graphs = 0;
    while (sent < EDGE_TARGET) begin
      if (sent < EDGE_TARGET / 3) begin
        send_idle_pct = 30; recv_idle_pct = 77;
      end else if (sent < 2 * EDGE_TARGET / 3) begin
        send_idle_pct = 77; recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (graphs % 4 == 0) begin
        side = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        write_side(side);
      end
      send_random_graph(side, $urandom_range(99) < 15, sent);
      graphs++;
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("min_cost_bipartite_assignment_test: clean");
    end else begin
      $display("min_cost_bipartite_assignment_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/mcba_pkg.sv
sv/mcba_edge_if.sv
sv/mcba_result_if.sv
sv/mcba_ram.sv
sv/min_cost_bipartite_assignment.sv
sv/mcba_checker.sv
sim/min_cost_bipartite_assignment_test.sv
